FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/acc_alu_pkg.sv
// ----------------------------------------------------------------------------
// Accumulator ALU package
// Command codes, field widths and default sizes for the accumulator ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acc_alu_pkg;

	localparam int unsigned DATA_WIDTH_DEF = 32;
	localparam int unsigned CMD_W          = 4;
	localparam int unsigned OPERAND_W      = 32;
	localparam int unsigned SHAMT_W        = 5;
	localparam int unsigned RESULT_W       = 32;
	localparam int unsigned IN_TDATA_W     = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 4'd0,
		CMD_INC  = 4'd1,
		CMD_DEC  = 4'd2,
		CMD_ADD  = 4'd3,
		CMD_SUB  = 4'd4,
		CMD_MUL  = 4'd5,
		CMD_NEG  = 4'd6,
		CMD_SHL  = 4'd7,
		CMD_SAR  = 4'd8,
		CMD_READ = 4'd9
	} cmd_t;

endpackage

FILE: rtl/acc_alu_adder.sv
// ----------------------------------------------------------------------------
// Accumulator ALU shared adder
// The one carry-propagate adder that every add, subtract, increment, decrement, negate and multiply step uses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acc_alu_adder #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	input  logic                  cin,
	output logic [DATA_WIDTH-1:0] sum
);

	always_comb begin
		sum = a + b + DATA_WIDTH'(cin);
	end

endmodule

FILE: rtl/accumulator_alu_shift_add_multiply.sv
// ----------------------------------------------------------------------------
// Accumulator ALU with shift-add multiplier
// Sequencer, accumulator and output register around one shared adder.
// ----------------------------------------------------------------------------
// Each command item updates the accumulator and returns its new value as one
// result item. Load, increment, decrement, add, subtract, negate, the shifts
// and read pass through ST_EXEC and ST_DONE before the result is offered.
// Multiply forms the operand magnitudes in ST_ABS_A and ST_ABS_B, takes one
// shift-add step per multiplier bit in ST_MUL and applies a sign correction
// in ST_FIX, all through the single shared adder. The block accepts one
// item at a time and is ready again once the result sits in the output
// register, even if that result has not yet been taken.
`timescale 1ns / 1ps

module accumulator_alu_shift_add_multiply #(
	parameter int unsigned DATA_WIDTH = acc_alu_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// operand [31:0], shift_amount [36:32], zero padding [39:37]
	input  logic [acc_alu_pkg::IN_TDATA_W-1:0] s_tdata,
	// command [3:0]
	input  logic [acc_alu_pkg::CMD_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// result_value [31:0]
	output logic [acc_alu_pkg::RESULT_W-1:0]   m_tdata
);

	import acc_alu_pkg::*;

	`include "assert_macros.svh"

	localparam int unsigned CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ABS_A,
		ST_ABS_B,
		ST_MUL,
		ST_FIX,
		ST_DONE
	} state_t;

	state_t                  state_q;
	cmd_t                    cmd_q;
	logic [DATA_WIDTH-1:0]   op_q;
	logic [SHAMT_W-1:0]      amt_q;
	logic [DATA_WIDTH-1:0]   acc_q;
	logic [DATA_WIDTH-1:0]   mcand_q;
	logic [DATA_WIDTH-1:0]   mplier_q;
	logic [DATA_WIDTH-1:0]   prod_q;
	logic                    neg_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    m_tvalid_q;
	logic [RESULT_W-1:0]     m_tdata_q;

	logic [DATA_WIDTH-1:0]   add_a;
	logic [DATA_WIDTH-1:0]   add_b;
	logic                    add_cin;
	logic [DATA_WIDTH-1:0]   add_sum;
	logic [DATA_WIDTH-1:0]   exec_res;
	logic                    s_accept;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	acc_alu_adder #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_adder (
		.a   (add_a),
		.b   (add_b),
		.cin (add_cin),
		.sum (add_sum)
	);

	// Operand selection for the shared adder in each sequencer state.
	always_comb begin
		add_a   = acc_q;
		add_b   = '0;
		add_cin = 1'b0;
		unique case (state_q)
			ST_EXEC: begin
				unique case (cmd_q)
					CMD_INC: begin
						add_cin = 1'b1;
					end
					CMD_DEC: begin
						add_b = '1;
					end
					CMD_ADD: begin
						add_b = op_q;
					end
					CMD_SUB: begin
						add_b   = ~op_q;
						add_cin = 1'b1;
					end
					CMD_NEG: begin
						add_a   = ~acc_q;
						add_cin = 1'b1;
					end
					default: begin
						add_cin = 1'b0;
					end
				endcase
			end
			ST_ABS_A: begin
				add_a   = ~acc_q;
				add_cin = 1'b1;
			end
			ST_ABS_B: begin
				add_a   = ~op_q;
				add_cin = 1'b1;
			end
			ST_MUL: begin
				add_a = prod_q;
				add_b = mplier_q[0] ? mcand_q : '0;
			end
			ST_FIX: begin
				add_a   = neg_q ? ~prod_q : prod_q;
				add_cin = neg_q;
			end
			default: begin
				add_cin = 1'b0;
			end
		endcase
	end

	// Result of the single-step commands.
	always_comb begin
		unique case (cmd_q)
			CMD_LOAD: exec_res = op_q;
			CMD_INC,
			CMD_DEC,
			CMD_ADD,
			CMD_SUB,
			CMD_NEG:  exec_res = add_sum;
			CMD_SHL:  exec_res = acc_q << amt_q;
			CMD_SAR:  exec_res = DATA_WIDTH'($signed(acc_q) >>> amt_q);
			default:  exec_res = acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmd_q      <= CMD_READ;
			op_q       <= '0;
			amt_q      <= '0;
			acc_q      <= '0;
			mcand_q    <= '0;
			mplier_q   <= '0;
			prod_q     <= '0;
			neg_q      <= 1'b0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						cmd_q   <= cmd_t'(s_tuser);
						op_q    <= DATA_WIDTH'($signed(s_tdata[OPERAND_W-1:0]));
						amt_q   <= s_tdata[OPERAND_W +: SHAMT_W];
						state_q <= (cmd_t'(s_tuser) == CMD_MUL) ? ST_ABS_A : ST_EXEC;
					end
				end
				ST_EXEC: begin
					acc_q   <= exec_res;
					state_q <= ST_DONE;
				end
				ST_ABS_A: begin
					mcand_q <= acc_q[DATA_WIDTH-1] ? add_sum : acc_q;
					neg_q   <= acc_q[DATA_WIDTH-1] ^ op_q[DATA_WIDTH-1];
					state_q <= ST_ABS_B;
				end
				ST_ABS_B: begin
					mplier_q <= op_q[DATA_WIDTH-1] ? add_sum : op_q;
					prod_q   <= '0;
					cnt_q    <= CNT_W'(DATA_WIDTH - 1);
					state_q  <= ST_MUL;
				end
				ST_MUL: begin
					prod_q   <= add_sum;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					acc_q   <= add_sum;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= RESULT_W'(acc_q);
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_CLK(a_busy_after_accept, s_accept |=> !s_tready, "ALU ready right after accepting an item")
	`ASSERT_CLK(a_result_from_done, $rose(m_tvalid) |-> $past(state_q == ST_DONE), "Result offered outside the done step")
	`ASSERT_CLK(a_mul_ends, (state_q == ST_MUL && cnt_q == '0) |=> state_q == ST_FIX, "Multiply did not end after its last bit")
	`ASSERT_NEVER(a_no_drop, state_q == ST_IDLE && $past(state_q == ST_DONE) && !m_tvalid, "Result lost on leaving the done step")

endmodule
